// ----- hdl/mss_pkg.sv -----
// Shared types and constants for the bounded maximum rectangle sum block.
`default_nettype none
package mss_pkg;

	// Field widths fixed by the interface.
	localparam int ELEM_W   = 16;
	localparam int BOUND_W  = 28;
	localparam int SIZE_W   = 9;
	localparam int TOT_W    = 2 * SIZE_W;
	localparam int APB_AW   = 4;
	localparam int APB_DW   = 32;

	// Register indexes (paddr[3:2]).
	localparam logic [1:0] REG_BOUND = 2'd0;
	localparam logic [1:0] REG_ROWS  = 2'd1;
	localparam logic [1:0] REG_COLS  = 2'd2;

	// Search sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_PAIR,
		S_ROW_RD,
		S_ROW_ADD,
		S_SCAN,
		S_FIN,
		S_DONE
	} mss_state_t;

	// Configuration seen by the search engine.
	typedef struct packed {
		logic signed [BOUND_W-1:0] bound;
		logic [SIZE_W-1:0]         rows;
		logic [SIZE_W-1:0]         cols;
	} mss_cfg_t;

	// Status and result from the search engine.
	typedef struct packed {
		logic                      busy;
		logic                      done;
		logic signed [BOUND_W-1:0] best;
		logic                      found;
	} mss_status_t;

endpackage
`default_nettype wire

// ----- hdl/mss_search.sv -----
// Search engine: row sum memory, sorted prefix memory and the search sequencer.
`default_nettype none
module mss_search
	import mss_pkg::*;
#(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire mss_cfg_t                 cfg,
	input  wire logic                     start,
	input  wire logic                     res_ready,
	output logic [((MAX_ROWS*MAX_COLS > 1) ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] mat_raddr,
	input  wire logic signed [ELEM_W-1:0] mat_rdata,
	output mss_status_t                   status
);

	localparam int AW   = (MAX_ROWS*MAX_COLS > 1) ? $clog2(MAX_ROWS*MAX_COLS) : 1;
	localparam int SW0  = 18 + $clog2(MAX_ROWS*MAX_COLS);
	localparam int SW   = (SW0 > BOUND_W + 1) ? SW0 : BOUND_W + 1;
	localparam int RIW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CIW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int SAW  = $clog2(MAX_ROWS + 1);
	localparam int CNW  = $clog2(MAX_ROWS + 2);

	mss_state_t state_q, state_n;

	logic [CIW-1:0]       left_q, right_q;
	logic [RIW-1:0]       row_q;
	logic [AW-1:0]        addr_q;
	logic [CNW-1:0]       count_q;
	logic [SAW-1:0]       idx_q;
	logic signed [SW-1:0] prefix_q, floor_q, candp_q, best_q;
	logic                 ins_q, have_q, found_q;

	// Memories and their registered read data.
	logic signed [SW-1:0] rs_mem [MAX_ROWS];
	logic signed [SW-1:0] st_mem [MAX_ROWS+1];
	logic signed [SW-1:0] rs_rd_q, st_rd_q;

	logic                 st_we;
	logic [SAW-1:0]       st_waddr, st_raddr;
	logic signed [SW-1:0] st_wdata;

	logic signed [SW-1:0] elem_ext, row_sum, prefix_new, cand;
	logic                 ge_floor, ge_v, last_row, last_right, last_left, idx_zero;

	// Arithmetic on the current row and scan entry.
	always_comb begin
		elem_ext   = SW'(mat_rdata);
		row_sum    = (left_q == right_q) ? elem_ext : rs_rd_q + elem_ext;
		prefix_new = prefix_q + row_sum;
		cand       = prefix_q - candp_q;
		ge_floor   = st_rd_q >= floor_q;
		ge_v       = st_rd_q >= prefix_q;
		last_row   = (SIZE_W'(row_q) + SIZE_W'(1)) == cfg.rows;
		last_right = (SIZE_W'(right_q) + SIZE_W'(1)) == cfg.cols;
		last_left  = (SIZE_W'(left_q) + SIZE_W'(1)) == cfg.cols;
		idx_zero   = idx_q == '0;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state and memory controls.
	always_comb begin
		state_n  = state_q;
		st_we    = 1'b0;
		st_waddr = '0;
		st_wdata = '0;
		st_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_n = S_PAIR;
				end
			end
			S_PAIR: begin
				st_we   = 1'b1;
				state_n = S_ROW_RD;
			end
			S_ROW_RD: begin
				state_n = S_ROW_ADD;
			end
			S_ROW_ADD: begin
				st_raddr = SAW'(count_q - CNW'(1));
				state_n  = S_SCAN;
			end
			S_SCAN: begin
				st_raddr = idx_zero ? '0 : idx_q - SAW'(1);
				if (!ins_q) begin
					st_we    = 1'b1;
					st_waddr = idx_q + SAW'(1);
					st_wdata = ge_v ? st_rd_q : prefix_q;
				end
				state_n = idx_zero ? S_FIN : S_SCAN;
			end
			S_FIN: begin
				if (!ins_q) begin
					st_we    = 1'b1;
					st_wdata = prefix_q;
				end
				if (last_row) begin
					state_n = (last_right && last_left) ? S_DONE : S_PAIR;
				end else begin
					state_n = S_ROW_RD;
				end
			end
			S_DONE: begin
				if (res_ready) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// Memory ports, read data registered.
	always_ff @(posedge clk) begin
		rs_rd_q <= rs_mem[row_q];
		st_rd_q <= st_mem[st_raddr];
		if (state_q == S_ROW_ADD) begin
			rs_mem[row_q] <= row_sum;
		end
		if (st_we) begin
			st_mem[st_waddr] <= st_wdata;
		end
	end

	// Search datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q  <= '0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					left_q  <= '0;
					right_q <= '0;
					if (start) begin
						best_q  <= '0;
						found_q <= 1'b0;
					end
				end
				S_PAIR: begin
					row_q    <= '0;
					addr_q   <= AW'(right_q);
					prefix_q <= '0;
					count_q  <= CNW'(1);
				end
				S_ROW_ADD: begin
					prefix_q <= prefix_new;
					floor_q  <= prefix_new - SW'(cfg.bound);
					idx_q    <= SAW'(count_q - CNW'(1));
					ins_q    <= 1'b0;
					have_q   <= 1'b0;
				end
				S_SCAN: begin
					if (ge_floor) begin
						have_q  <= 1'b1;
						candp_q <= st_rd_q;
					end
					if (!ins_q && !ge_v) begin
						ins_q <= 1'b1;
					end
					idx_q <= idx_q - SAW'(1);
				end
				S_FIN: begin
					if (have_q && (!found_q || cand > best_q)) begin
						best_q  <= cand;
						found_q <= 1'b1;
					end
					count_q <= count_q + CNW'(1);
					row_q   <= row_q + RIW'(1);
					addr_q  <= addr_q + AW'(cfg.cols);
					if (last_row) begin
						if (!last_right) begin
							right_q <= right_q + CIW'(1);
						end else if (!last_left) begin
							left_q  <= left_q + CIW'(1);
							right_q <= left_q + CIW'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign mat_raddr    = addr_q;
	assign status.busy  = state_q != S_IDLE;
	assign status.done  = (state_q == S_DONE) && res_ready;
	assign status.best  = found_q ? BOUND_W'(best_q) : '0;
	assign status.found = found_q;

endmodule
`default_nettype wire

// ----- hdl/max_submatrix_sum_bounded_top.sv -----
// Top level: configuration registers, matrix store, load counter and result register.
//
//  Channel   Direction  Handshake                Payload
//  input     in         in_valid / in_stall      element
//  output    out        out_valid / out_stall    best_sum, found
//  config    in         APB psel/penable/pready  paddr, pwdata, prdata
//
// Elements are loaded while the input is not stalled. After the last element the
// search runs, scanning the sorted prefix memory one entry per cycle. Input is
// stalled while the search runs and while its result waits for the output
// register. Reset clears control state only; the memories hold no reset value.
// The result register frees when taken.
`default_nettype none
module max_submatrix_sum_bounded_top
	import mss_pkg::*;
#(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic signed [ELEM_W-1:0]  element,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic signed [BOUND_W-1:0]      best_sum,
	output logic                           found,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [APB_AW-1:0]         paddr,
	input  wire logic [APB_DW-1:0]         pwdata,
	output logic [APB_DW-1:0]              prdata,
	output logic                           pready
);

	localparam int AW = (MAX_ROWS*MAX_COLS > 1) ? $clog2(MAX_ROWS*MAX_COLS) : 1;

	logic signed [BOUND_W-1:0] bound_q;
	logic [SIZE_W-1:0]         rows_q, cols_q;
	logic [SIZE_W-1:0]         size_raw, rows_clamp, cols_clamp;
	logic                      cfg_wr;

	logic [AW-1:0]             cnt_q;
	logic [TOT_W-1:0]          total;
	logic                      in_take, complete;

	logic signed [ELEM_W-1:0]  mat_mem [MAX_ROWS*MAX_COLS];
	logic signed [ELEM_W-1:0]  mat_rd_q;
	logic [AW-1:0]             mat_raddr;

	logic                      out_valid_q, found_q;
	logic signed [BOUND_W-1:0] best_q;

	mss_cfg_t                  cfg;
	mss_status_t               status;

	// Size clamping on pwdata[6:0]: zero acts as one, values above the maximum saturate.
	always_comb begin
		size_raw   = (pwdata[6:0] == 7'd0) ? SIZE_W'(1) : SIZE_W'(pwdata[6:0]);
		rows_clamp = (size_raw > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : size_raw;
		cols_clamp = (size_raw > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : size_raw;
	end

	// Configuration writes.
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q <= '0;
			rows_q  <= SIZE_W'(1);
			cols_q  <= SIZE_W'(1);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_BOUND: bound_q <= pwdata[BOUND_W-1:0];
				REG_ROWS:  rows_q  <= rows_clamp;
				REG_COLS:  cols_q  <= cols_clamp;
				default: begin
				end
			endcase
		end
	end

	// Register read back.
	always_comb begin
		case (paddr[3:2])
			REG_BOUND: prdata = APB_DW'(bound_q);
			REG_ROWS:  prdata = APB_DW'(rows_q);
			REG_COLS:  prdata = APB_DW'(cols_q);
			default:   prdata = '0;
		endcase
	end

	// Load counter; the matrix completes when the count reaches or passes the current size.
	assign in_stall = status.busy;
	assign in_take  = in_valid && !in_stall;
	assign total    = TOT_W'(rows_q) * TOT_W'(cols_q);
	assign complete = (TOT_W'(cnt_q) + TOT_W'(1)) >= total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_take) begin
			cnt_q <= complete ? '0 : cnt_q + AW'(1);
		end
	end

	// Matrix store with a registered read port for the search engine.
	always_ff @(posedge clk) begin
		if (in_take) begin
			mat_mem[cnt_q] <= element;
		end
		mat_rd_q <= mat_mem[mat_raddr];
	end

	assign cfg.bound = bound_q;
	assign cfg.rows  = rows_q;
	assign cfg.cols  = cols_q;

	mss_search #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.start     (in_take && complete),
		.res_ready (!out_valid_q),
		.mat_raddr (mat_raddr),
		.mat_rdata (mat_rd_q),
		.status    (status)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (status.done) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (status.done) begin
			best_q  <= status.best;
			found_q <= status.found;
		end
	end

	assign out_valid = out_valid_q;
	assign best_sum  = best_q;
	assign found     = found_q;

endmodule
`default_nettype wire

// ----- hdl/mss_checker.sv -----
// Port-level checker for the bounded maximum rectangle sum block, with its bind.
`default_nettype none
module mss_checker
	import mss_pkg::*;
(
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     in_stall,
	input wire logic                     out_valid,
	input wire logic                     out_stall,
	input wire logic signed [BOUND_W-1:0] best_sum,
	input wire logic                     found,
	input wire logic                     pready
);

	// A stalled result transaction holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(best_sum) && $stable(found))
		else $error("stalled result changed");

	// No rectangle found means a zero sum.
	a_zero_when_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> best_sum == '0)
		else $error("best_sum nonzero without found");

	// A result appears only after a search that stalled the input.
	a_result_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a preceding search");

	// The configuration port never waits.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind max_submatrix_sum_bounded_top mss_checker u_mss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.best_sum  (best_sum),
	.found     (found),
	.pready    (pready)
);
`default_nettype wire

// ----- bench/max_submatrix_sum_bounded_top_test.sv -----
// Self-checking testbench for the bounded maximum rectangle sum block.
`default_nettype none
module max_submatrix_sum_bounded_top_test;
	import mss_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_DIM = 64;
	localparam int IDLE_LIMIT = 100000;
	localparam logic [1:0] REG_SPARE = 2'd3;

	// Keeps the configuration, the loaded matrix and the queue of expected sums.
	class rect_sum_board;
		longint bound;
		int rows;
		int cols;
		shortint mat[MAX_DIM*MAX_DIM];
		int load_cnt;
		logic [BOUND_W-1:0] want_sum[$];
		logic want_found[$];
		int errors;

		function new();
			bound = 0;
			rows = 1;
			cols = 1;
			load_cnt = 0;
			errors = 0;
		endfunction

		function int fit_size(logic [31:0] v);
			int s;
			s = v[6:0];
			if (s == 0) s = 1;
			if (s > MAX_DIM) s = MAX_DIM;
			return s;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] v);
			case (idx)
				REG_BOUND: bound = longint'($signed(v[BOUND_W-1:0]));
				REG_ROWS: rows = fit_size(v);
				REG_COLS: cols = fit_size(v);
				default: ;
			endcase
		endfunction

		// Column pair sweep with a sorted list of earlier prefixes; query before insert.
		function void best_rectangle();
			longint row_acc[MAX_DIM];
			longint sorted[MAX_DIM+1];
			int n;
			longint prefix;
			longint floor_v;
			longint best;
			bit hit;
			int q;
			int pos;
			best = 0;
			hit = 0;
			for (int l = 0; l < cols; l++) begin
				for (int r = 0; r < rows; r++) row_acc[r] = 0;
				for (int rt = l; rt < cols; rt++) begin
					for (int r = 0; r < rows; r++) row_acc[r] += mat[r*cols + rt];
					n = 1;
					sorted[0] = 0;
					prefix = 0;
					for (int r = 0; r < rows; r++) begin
						prefix += row_acc[r];
						floor_v = prefix - bound;
						q = 0;
						while (q < n && sorted[q] < floor_v) q++;
						if (q < n && (!hit || prefix - sorted[q] > best)) begin
							best = prefix - sorted[q];
							hit = 1;
						end
						pos = 0;
						while (pos < n && sorted[pos] < prefix) pos++;
						for (int i = n; i > pos; i--) sorted[i] = sorted[i-1];
						sorted[pos] = prefix;
						n++;
					end
				end
			end
			want_sum.push_back(hit ? best[BOUND_W-1:0] : '0);
			want_found.push_back(hit);
		endfunction

		// Notes one accepted element; the last one of a matrix queues a result.
		function void note_element(logic signed [ELEM_W-1:0] e);
			if (load_cnt < MAX_DIM*MAX_DIM) mat[load_cnt] = e;
			if (load_cnt + 1 >= rows*cols) begin
				load_cnt = 0;
				best_rectangle();
			end else begin
				load_cnt++;
			end
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		// Compares one accepted result with the oldest expectation.
		task check_result(logic [BOUND_W-1:0] s, logic f);
			logic [BOUND_W-1:0] es;
			logic ef;
			if (want_sum.size() == 0) begin
				report($sformatf("unexpected result sum=%0d found=%0b", $signed(s), f));
			end else begin
				es = want_sum.pop_front();
				ef = want_found.pop_front();
				if (f !== ef)
					report($sformatf("found %0b, expected %0b", f, ef));
				if (s !== es)
					report($sformatf("best_sum %0d, expected %0d", $signed(s), $signed(es)));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [ELEM_W-1:0] element;
	logic out_valid;
	logic out_stall;
	logic signed [BOUND_W-1:0] best_sum;
	logic found;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	rect_sum_board board;
	int idle_cycles;
	int items_sent;
	bit tx_gaps;
	bit rx_gaps;
	int hold_left;

	max_submatrix_sum_bounded_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .element(element),
		.out_valid(out_valid), .out_stall(out_stall), .best_sum(best_sum), .found(found),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Clock and a single reset pulse.
	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		board = new();
		arst_n = 0;
		in_valid = 0;
		element = '0;
		out_stall = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
	end

	// Monitor: every accepted transaction on the input and output channels.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) board.note_element(element);
			if (out_valid && !out_stall) board.check_result(best_sum, found);
		end
	end

	// Receiver: random stalls, plus a long hold-off when requested.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1;
		end else begin
			out_stall <= rx_gaps && ($urandom_range(99) < 16);
		end
	end

	// Watchdog on cycles without any accepted transaction.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("max_submatrix_sum_bounded_top_test: errors");
			$finish;
		end
	end

	task write_reg(logic [1:0] idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		board.set_reg(idx, v);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task send_element(logic signed [ELEM_W-1:0] e);
		if (tx_gaps && $urandom_range(99) < 16) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		element <= e;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	// Lets every expected result arrive, then waits out loads in flight.
	// The first edge lets the monitor note the last accepted element.
	task drain();
		in_valid <= 0;
		@(posedge clk);
		while (board.want_sum.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	function logic signed [ELEM_W-1:0] pick_element();
		case ($urandom_range(7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return ELEM_W'($urandom_range(200) - 100);
			default: return ELEM_W'($urandom);
		endcase
	endfunction

	function logic [31:0] pick_bound();
		case ($urandom_range(7))
			0: return 32'h07ff_ffff;
			1: return 32'h0800_0000;
			2: return 32'd0;
			3: return 32'($urandom_range(100000)) - 32'd50000;
			4: return 32'($urandom_range(2000)) - 32'd1000;
			default: return $urandom;
		endcase
	endfunction

	// Stimulus: directed cases, then random matrices in phases.
	initial begin
		int phase;
		int nmat;
		int shape;
		hold_left = 0;
		idle_cycles = 0;
		items_sent = 0;
		tx_gaps = 1;
		rx_gaps = 1;
		@(posedge arst_n);
		repeat (2) @(posedge clk);

		// Reset sizes give one-element matrices with a bound of zero.
		send_element(16'sh7fff);
		send_element(16'sh8000);
		send_element(16'sh0000);
		drain();
		// Zero sizes act as one; an unknown register is ignored.
		write_reg(REG_ROWS, 32'd0);
		write_reg(REG_COLS, 32'h80);
		write_reg(REG_SPARE, 32'd5);
		send_element(16'sh0001);
		drain();
		// Lowest bound with all-minimum elements.
		write_reg(REG_ROWS, 32'd2);
		write_reg(REG_COLS, 32'd2);
		write_reg(REG_BOUND, 32'h0800_0000);
		repeat (4) send_element(16'sh8000);
		drain();
		write_reg(REG_BOUND, 32'h07ff_ffff);
		send_element(16'sh7fff);
		send_element(16'sh8000);
		send_element(16'sh7fff);
		send_element(16'sh7fff);
		drain();
		// Sizes shrink while a matrix is partly loaded.
		write_reg(REG_BOUND, 32'd100);
		write_reg(REG_COLS, 32'd3);
		repeat (3) send_element(pick_element());
		drain();
		write_reg(REG_COLS, 32'd1);
		send_element(16'sh0050);
		drain();

		// Random phases until enough items have passed.
		phase = 0;
		while (items_sent < 290) begin
			tx_gaps = !(phase >= 6 && phase <= 10);
			rx_gaps = tx_gaps;
			shape = $urandom_range(11);
			if (shape == 0) begin
				write_reg(REG_ROWS, 32'd127);
				write_reg(REG_COLS, 32'd1);
			end else if (shape == 1) begin
				write_reg(REG_ROWS, 32'd1);
				write_reg(REG_COLS, 32'd64);
			end else begin
				write_reg(REG_ROWS, 32'($urandom_range(5, 1)));
				write_reg(REG_COLS, 32'($urandom_range(5, 1)));
			end
			write_reg(REG_BOUND, pick_bound());
			if (phase == 3) begin
				// Long output hold-off so the result register fills and input stalls.
				write_reg(REG_ROWS, 32'd1);
				write_reg(REG_COLS, 32'd1);
				hold_left = 300;
				repeat (10) send_element(pick_element());
			end else begin
				nmat = (shape <= 1) ? 1 : $urandom_range(3, 1);
				repeat (nmat * board.rows * board.cols) send_element(pick_element());
				// Now and then leave a matrix unfinished before resizing.
				if ($urandom_range(5) == 0)
					repeat ($urandom_range(3, 1)) send_element(pick_element());
			end
			drain();
			phase++;
		end

		drain();
		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.want_sum.size() == 0)
			$display("max_submatrix_sum_bounded_top_test: clean");
		else
			$display("max_submatrix_sum_bounded_top_test: errors");
		$finish;
	end
endmodule
`default_nettype wire
